### rtl/stph_pkg.sv
// ============================================================================
// stph_pkg
// Shared types and constants for the seed text parse-or-hash unit.
// ============================================================================
package stph_pkg;

   localparam logic [20:0] REPL_CP   = 21'h00FFFD;
   localparam logic [20:0] MAX_CP    = 21'h10FFFF;
   localparam logic [20:0] SUPP_BASE = 21'h010000;
   localparam logic [15:0] HI_SURR   = 16'hD800;
   localparam logic [15:0] LO_SURR   = 16'hDC00;
   localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

   // One-hot controller states
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,   // waiting for a word
      ST_HASH   = 5'b00010,   // pushing queued hash units
      ST_DIGIT  = 5'b00100,   // numeric update after decode
      ST_FINAL  = 5'b01000,   // end-of-text replay done, form result
      ST_OUT    = 5'b10000    // result held until taken
   } state_type;

   // Controller -> datapath commands
   typedef struct packed {
      logic load;     // capture the accepted word
      logic decode;   // classify byte, queue hash units
      logic hash;     // apply one queued hash unit
      logic digit;    // numeric tracker update
      logic flush;    // queue replay of an open sequence
      logic finish;   // build result word
      logic clear;    // back to reset state
   } cmd_type;

   // Datapath -> controller status
   typedef struct packed {
      logic units_left;   // hash units still queued
      logic last;         // captured word ends the text
      logic present;      // captured word carries a byte
      logic taken;        // byte passed the leading-space filter
   } sts_type;

   function automatic logic is_ws(input logic [7:0] b);
      return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0B ||
             b == 8'h0C || b == 8'h0D;
   endfunction

endpackage

### rtl/stph_ctrl.sv
// ============================================================================
// stph_ctrl
// Sequencer: load, decode, drain hash units, numeric update, result.
// ============================================================================
module stph_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  stph_pkg::sts_type sts,
   output stph_pkg::cmd_type cmd
);
   import stph_pkg::*;

   state_type state_ff, state_in;
   logic      fin_ff, fin_in;   // hash drain belongs to end-of-text

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = state_ff == ST_OUT;

   always_comb begin
      state_in = state_ff;
      fin_in   = fin_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_HASH;
               fin_in   = 1'b0;
            end
         end
         ST_HASH: begin
            // after load: decode first (kept byte only); then drain queue
            if (sts.units_left) begin
               cmd.hash = 1'b1;
            end else if (fin_ff) begin
               state_in = ST_FINAL;
            end else begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            cmd.digit = sts.present && sts.taken;
            if (sts.last) begin
               cmd.flush = 1'b1;
               fin_in    = 1'b1;
               state_in  = ST_HASH;
            end else begin
               state_in  = ST_IDLE;
            end
         end
         ST_FINAL: begin
            cmd.finish = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
      end
   end

endmodule

### rtl/stph_dpath.sv
// ============================================================================
// stph_dpath
// UTF-8 decode, hash unit queue, decimal tracker and result register.
// ============================================================================
module stph_dpath (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        in_byte,
   input  logic              in_present,
   input  logic              in_last,
   input  stph_pkg::cmd_type cmd,
   output stph_pkg::sts_type sts,
   output logic [63:0]       seed_value,
   output logic              seed_found,
   output logic              from_number
);
   import stph_pkg::*;

   logic [7:0]  byte_ff;
   logic        pres_ff, last_ff, taken_ff, dec_ff;
   logic [20:0] part_ff;
   logic [1:0]  exp_ff, rcv_ff;
   logic [31:0] hrun_ff, hcom_ff;
   // queue: up to three replacement units, then one code point (one unit or two halves)
   logic [2:0]  nrep_ff;
   logic        cp_v_ff, cp_ws_ff, lo_v_ff;
   logic [15:0] cp_u_ff, lo_u_ff;
   logic [63:0] mag_ff;
   logic        neg_ff, num_ff, dig_ff, start_ff, spend_ff, first_ff;
   logic [63:0] out_v_ff;
   logic        out_f_ff, out_n_ff;

   assign sts.units_left = dec_ff || nrep_ff != '0 || cp_v_ff || lo_v_ff;
   assign sts.last       = last_ff;
   assign sts.present    = pres_ff;
   assign sts.taken      = taken_ff;
   assign seed_value     = out_v_ff;
   assign seed_found     = out_f_ff;
   assign from_number    = out_n_ff;

   // decode of the held byte
   logic        b_ws, b_cont, b_done, b_bad;
   logic [20:0] b_code;
   logic [20:0] b_low, cp_sel, rest;
   always_comb begin
      b_ws   = is_ws(byte_ff);
      b_cont = byte_ff[7:6] == 2'b10;
      b_code = {part_ff[14:0], byte_ff[5:0]};
      b_done = exp_ff != 2'd0 && b_cont && (rcv_ff + 2'd1) == exp_ff;
      b_low  = exp_ff == 2'd1 ? 21'h80 : (exp_ff == 2'd2 ? 21'h800 : SUPP_BASE);
      b_bad  = b_code < b_low || b_code > MAX_CP ||
               (b_code >= 21'hD800 && b_code <= 21'hDFFF);
      cp_sel = b_bad ? REPL_CP : b_code;
      rest   = cp_sel - SUPP_BASE;
   end

   // one hash step on the head of the queue
   logic [15:0] unit;
   logic        unit_ws;
   always_comb begin
      unit_ws = 1'b0;
      if (nrep_ff != '0)      unit = REPL_CP[15:0];
      else if (cp_v_ff) begin
         unit = cp_u_ff; unit_ws = cp_ws_ff;
      end else                unit = lo_u_ff;
   end
   logic [31:0] h_next;
   assign h_next = {hrun_ff[26:0], 5'd0} - hrun_ff + {16'd0, unit};

   // decimal step
   logic [3:0]  dgt;
   logic [63:0] lim, mag10;
   logic        over;
   assign dgt   = byte_ff[3:0];
   assign lim   = neg_ff ? NEG_LIMIT : POS_LIMIT;
   assign mag10 = {mag_ff[60:0], 3'd0} + {mag_ff[62:0], 1'b0};
   // magnitude*10 + digit > limit, with overflow of *10 caught by top bits
   assign over  = mag_ff > 64'h0CCC_CCCC_CCCC_CCCC ||
                  (mag10 + {60'd0, dgt}) > lim;

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         dec_ff <= 1'b0; nrep_ff <= '0; cp_v_ff <= 1'b0; lo_v_ff <= 1'b0;
         part_ff <= '0; exp_ff <= '0; rcv_ff <= '0;
         hrun_ff <= '0; hcom_ff <= '0; mag_ff <= '0;
         neg_ff <= 1'b0; num_ff <= 1'b1; dig_ff <= 1'b0;
         start_ff <= 1'b0; spend_ff <= 1'b0; first_ff <= 1'b0;
         taken_ff <= 1'b0; out_f_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            byte_ff  <= in_byte;
            pres_ff  <= in_present;
            last_ff  <= in_last;
            taken_ff <= in_present && (start_ff || !is_ws(in_byte));
            first_ff <= !start_ff;
            dec_ff   <= in_present && (start_ff || !is_ws(in_byte));
            if (in_present && !is_ws(in_byte)) start_ff <= 1'b1;
         end
         if (dec_ff) begin
            dec_ff <= 1'b0;
            if (exp_ff != 2'd0 && b_cont) begin
               part_ff <= b_code;
               rcv_ff  <= rcv_ff + 2'd1;
               if (b_done) begin
                  exp_ff  <= '0; rcv_ff <= '0; part_ff <= '0;
                  cp_ws_ff <= 1'b0;
                  if (cp_sel >= SUPP_BASE) begin
                     cp_v_ff <= 1'b1; cp_u_ff <= HI_SURR + {6'd0, rest[19:10]};
                     lo_v_ff <= 1'b1; lo_u_ff <= LO_SURR + {6'd0, rest[9:0]};
                  end else begin
                     cp_v_ff <= 1'b1; cp_u_ff <= cp_sel[15:0];
                  end
               end
            end else begin
               nrep_ff <= exp_ff != 2'd0 ? {1'b0, rcv_ff} + 3'd1 : 3'd0;
               exp_ff  <= '0; rcv_ff <= '0; part_ff <= '0;
               cp_ws_ff <= b_ws;
               if (!byte_ff[7]) begin
                  cp_v_ff <= 1'b1; cp_u_ff <= {8'd0, byte_ff};
               end else if (byte_ff[7:5] == 3'b110) begin
                  exp_ff <= 2'd1; part_ff <= {16'd0, byte_ff[4:0]};
               end else if (byte_ff[7:4] == 4'b1110) begin
                  exp_ff <= 2'd2; part_ff <= {17'd0, byte_ff[3:0]};
               end else if (byte_ff[7:3] == 5'b11110) begin
                  exp_ff <= 2'd3; part_ff <= {18'd0, byte_ff[2:0]};
               end else begin
                  cp_v_ff <= 1'b1; cp_u_ff <= REPL_CP[15:0];
               end
            end
         end else if (cmd.hash) begin
            hrun_ff <= h_next;
            if (!unit_ws) hcom_ff <= h_next;
            if (nrep_ff != '0) nrep_ff <= nrep_ff - 3'd1;
            else if (cp_v_ff)  cp_v_ff <= 1'b0;
            else               lo_v_ff <= 1'b0;
         end
         if (cmd.flush) begin
            nrep_ff <= exp_ff != 2'd0 ? {1'b0, rcv_ff} + 3'd1 : 3'd0;
            exp_ff  <= '0; rcv_ff <= '0; part_ff <= '0;
         end
         if (cmd.digit) begin
            if (b_ws) spend_ff <= 1'b1;
            else begin
               spend_ff <= 1'b0;
               if (first_ff && (byte_ff == 8'h2B || byte_ff == 8'h2D)) begin
                  neg_ff <= byte_ff == 8'h2D;
                  if (spend_ff) num_ff <= 1'b0;
               end else if (spend_ff || !num_ff) num_ff <= 1'b0;
               else if (byte_ff < 8'h30 || byte_ff > 8'h39 || over) num_ff <= 1'b0;
               else begin
                  mag_ff <= mag10 + {60'd0, dgt};
                  dig_ff <= 1'b1;
               end
            end
         end
         if (cmd.finish) begin
            out_f_ff <= start_ff;
            out_n_ff <= start_ff && num_ff && dig_ff;
            if (!start_ff) out_v_ff <= '0;
            else if (num_ff && dig_ff) out_v_ff <= neg_ff ? (~mag_ff + 64'd1) : mag_ff;
            else out_v_ff <= {{32{hcom_ff[31]}}, hcom_ff};
         end
      end
   end

endmodule

### rtl/seed_text_parse_or_hash_unit.sv
// ============================================================================
// seed_text_parse_or_hash_unit
// Trims a UTF-8 seed text; returns its signed decimal value or string hash.
// ============================================================================
// Per word: a kept byte is decoded, then each hash unit it queues (0..4) is
// applied in turn before the numeric update; a word without a kept byte
// skips both. One word at a time: a new word waits until the last is done.
// End-of-text word: replays an open sequence (0..3 units) as replacement
// hash units, then forms the result word, held until taken. Reset: synchronous,
// active high; all parse state cleared, no result pending.
module seed_text_parse_or_hash_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tuser,   // byte_present
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] seed_value
   output logic [1:0]  rsp_tuser    // [0] seed_found, [1] from_number
);
   import stph_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // controller sequences decode, hash drain and digit update per word
   stph_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready,
      .rsp_tvalid, .rsp_tready, .sts, .cmd
   );

   stph_dpath u_dpath (
      .clock, .reset,
      .in_byte     (req_tdata),
      .in_present  (req_tuser),
      .in_last     (req_tlast),
      .cmd, .sts,
      .seed_value  (rsp_tdata),
      .seed_found  (rsp_tuser[0]),
      .from_number (rsp_tuser[1])
   );

endmodule

### rtl/stph_checker.sv
// ============================================================================
// stph_checker
// Port-level checks for the seed text parse-or-hash unit.
// ============================================================================
module stph_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("accept while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
   a_num: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0]) else $error("number without seed");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 64'd0) else $error("empty not zero");
   a_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("back to back accept");
endmodule

bind seed_text_parse_or_hash_unit stph_checker u_chk (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tdata, .rsp_tuser
);
